[sv/dreq_pkg.sv]
// ----------------------------------------------------------------------------
// dreq_pkg
// Types and codes shared by the disk request elevator queue and its cells.
// ----------------------------------------------------------------------------
package dreq_pkg;

	// Result kinds
	localparam logic [1:0] KIND_ACCEPTED   = 2'd0;
	localparam logic [1:0] KIND_DROPPED    = 2'd1;
	localparam logic [1:0] KIND_DISPATCHED = 2'd2;
	localparam logic [1:0] KIND_EMPTY      = 2'd3;

	// Commands broadcast to the row of cells
	localparam logic [1:0] CMD_HOLD = 2'd0;
	localparam logic [1:0] CMD_ENQ  = 2'd1;
	localparam logic [1:0] CMD_DEQ  = 2'd2;

	// Request modes
	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	// Configuration register indexes
	localparam logic REG_MAX_BLOCK = 1'b0;
	localparam logic REG_MAX_SIZE  = 1'b1;

	localparam logic [10:0] MAX_BLOCK_RST = 11'd360;
	localparam logic [14:0] MAX_SIZE_RST  = 15'd9216;

	// Valid operations
	localparam logic [3:0] OP_READ  = 4'd1;
	localparam logic [3:0] OP_WRITE = 4'd2;

	// Width of a non-negative block number minus one
	localparam int NUM_W = 11;

	typedef struct packed {
		logic              mode;
		logic [3:0]        req_op;
		logic signed [15:0] req_id;
		logic signed [11:0] req_block;
		logic signed [15:0] req_size;
		logic [31:0]       req_addr;
		logic [7:0]        head_cyl;
	} req_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        out_op;
		logic signed [15:0] out_id;
		logic signed [11:0] out_block;
		logic signed [15:0] out_size;
		logic [31:0]       out_addr;
		logic [3:0]        error_flags;
		logic [7:0]        out_cyl;
		logic              out_track;
		logic [3:0]        out_sect;
		logic [5:0]        queue_level;
	} rsp_t;

	// One table entry, sorted on key (the block number)
	typedef struct packed {
		logic signed [11:0] key;
		logic [3:0]        op;
		logic signed [15:0] id;
		logic signed [15:0] size;
		logic [31:0]       addr;
	} ent_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       any_qual;
		ent_t       new_ent;
	} cell_ctl_t;

endpackage

[sv/dreq_cell.sv]
// ----------------------------------------------------------------------------
// dreq_cell
// One slot of the sorted request table. Inserts, shifts towards either
// neighbour and flags whether its block lies at or beyond the head cylinder.
// ----------------------------------------------------------------------------
module dreq_cell import dreq_pkg::*; #(
	parameter int TRACKS_PER_CYL = 9,
	parameter bit FIRST = 1'b0,
	localparam int HTW = 8 + $clog2(TRACKS_PER_CYL)
) (
	input  logic           clk,
	input  cell_ctl_t      ctl,
	input  logic [HTW-1:0] hthr,
	input  logic           occ,
	input  ent_t           left_ent,
	input  logic           left_le,
	input  logic           left_qual,
	input  ent_t           right_ent,
	output ent_t           ent,
	output logic           le,
	output logic           qual,
	output logic           sel,
	output ent_t           pick
);

	localparam int CW = (HTW > 12) ? HTW : 12;
	localparam logic [12:0] TPC = 13'(TRACKS_PER_CYL);

	ent_t        ent_q;
	logic [12:0] kb1;
	logic [12:0] kb1_mag;
	logic        take_right;

	assign ent = ent_q;

	// The table is sorted, so this is true on a prefix of the occupied slots.
	assign le = occ && (ent_q.key <= ctl.new_ent.key);

	// Cylinder is (block - 1) / tracks, truncated towards zero. A negative
	// numerator only reaches cylinder zero, and only when it is small enough.
	assign kb1     = {ent_q.key[11], ent_q.key} - 13'd1;
	assign kb1_mag = 13'd0 - kb1;
	always_comb begin
		if (kb1[12]) begin
			qual = occ && (hthr == '0) && (kb1_mag < TPC);
		end else begin
			qual = occ && (CW'(kb1[11:0]) >= CW'(hthr));
		end
	end

	// The qualifying slots form a suffix; the first of them is taken, or the
	// head slot when none qualifies.
	assign sel        = ctl.any_qual ? (qual && !left_qual) : FIRST;
	assign take_right = ctl.any_qual ? qual : 1'b1;
	assign pick       = sel ? ent_q : '0;

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CMD_ENQ: begin
				if (!le) begin
					ent_q <= left_le ? ctl.new_ent : left_ent;
				end
			end
			CMD_DEQ: begin
				if (take_right) begin
					ent_q <= right_ent;
				end
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
	end

endmodule

[sv/dreq_post.sv]
// ----------------------------------------------------------------------------
// dreq_post
// Checks a dispatched request and splits its block into cylinder, track and
// sector over two stages, then drives the result register.
// ----------------------------------------------------------------------------
module dreq_post import dreq_pkg::*; #(
	parameter int TRACKS_PER_CYL = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        v_s2,
	input  logic [1:0]  kind_s2,
	input  ent_t        pick_s2,
	input  logic [5:0]  level_s2,
	input  logic [10:0] max_block,
	input  logic [14:0] max_size,
	output logic        done,
	output rsp_t        result
);

	localparam int DIV_SH  = NUM_W + $clog2(TRACKS_PER_CYL);
	localparam int DIV_MUL = ((1 << DIV_SH) + TRACKS_PER_CYL - 1) / TRACKS_PER_CYL;
	localparam int PW      = DIV_SH + NUM_W;
	localparam int RW      = $clog2(TRACKS_PER_CYL);
	localparam int SW      = RW + 1;

	logic [3:0]       flags;
	logic [NUM_W-1:0] b1;
	logic [PW-1:0]    prod;
	logic [15:0]      size_m1;

	logic             v_s3;
	logic [1:0]       kind_s3;
	ent_t             pick_s3;
	logic [3:0]       flags_s3;
	logic [5:0]       level_s3;
	logic [NUM_W-1:0] b1_s3;
	logic [NUM_W-1:0] q_s3;

	logic [NUM_W-1:0] qt;
	logic [NUM_W-1:0] rem_w;
	logic [RW-1:0]    rem;
	logic             trk;
	logic [SW-1:0]    sec;
	rsp_t             rsp;
	logic             done_q;
	rsp_t             result_q;

	assign size_m1 = pick_s2.size - 16'sd1;

	always_comb begin
		flags    = '0;
		flags[0] = (pick_s2.op == 4'd0) || (pick_s2.op > OP_WRITE);
		flags[1] = pick_s2.id[15] || (pick_s2.id == '0);
		flags[2] = pick_s2.key[11] || (pick_s2.key == '0) || (pick_s2.key[10:0] > max_block);
		flags[3] = pick_s2.size[15] || ((pick_s2.size & size_m1) != '0) ||
			(pick_s2.size[14:0] > max_size);
	end

	// Quotient by the track count through a reciprocal that is exact for any
	// eleven-bit numerator.
	assign b1   = pick_s2.key[10:0] - 11'd1;
	assign prod = PW'(b1) * PW'(DIV_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			kind_s3  <= kind_s2;
			pick_s3  <= pick_s2;
			flags_s3 <= flags;
			level_s3 <= level_s2;
			b1_s3    <= b1;
			q_s3     <= prod[DIV_SH +: NUM_W];
		end
	end

	assign qt    = q_s3 * NUM_W'(TRACKS_PER_CYL);
	assign rem_w = b1_s3 - qt;
	assign rem   = rem_w[RW-1:0];

	always_comb begin
		if (rem <= RW'(TRACKS_PER_CYL / 2)) begin
			trk = 1'b0;
			sec = {rem, 1'b0};
		end else begin
			trk = 1'b1;
			sec = {rem, 1'b0} - SW'(TRACKS_PER_CYL);
		end
	end

	always_comb begin
		rsp             = '0;
		rsp.kind        = kind_s3;
		rsp.queue_level = level_s3;
		if (kind_s3 == KIND_DISPATCHED) begin
			rsp.out_op      = pick_s3.op;
			rsp.out_id      = pick_s3.id;
			rsp.out_block   = pick_s3.key;
			rsp.out_size    = pick_s3.size;
			rsp.out_addr    = pick_s3.addr;
			rsp.error_flags = flags_s3;
			if (flags_s3 == '0) begin
				rsp.out_cyl   = (q_s3 > 11'd255) ? 8'hFF : q_s3[7:0];
				rsp.out_track = trk;
				rsp.out_sect  = (sec > SW'(15)) ? 4'hF : 4'(sec);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			result_q <= rsp;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[sv/disk_request_elevator_queue.sv]
// ----------------------------------------------------------------------------
// disk_request_elevator_queue
// Sorted table of disk requests with C-LOOK dispatch, built as a row of cells.
// ----------------------------------------------------------------------------
//  channel   signals                           handshake
//  request   start, busy, cmd                  taken when start and not busy
//  result    done, result                      one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_idx, cfg_wdata        written when cfg_we is high
//
//  The cells insert or remove in the cycle after acceptance, during which busy
//  is high. The result strobe rises together with the result register, after a
//  checking stage and a position stage.
//  Reset clears the fill count and restores the registers; the table itself
//  is not cleared. Nothing can stall the result side.
// ----------------------------------------------------------------------------
module disk_request_elevator_queue import dreq_pkg::*; #(
	parameter int QUEUE_DEPTH    = 32,
	parameter int TRACKS_PER_CYL = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        cmd,
	output logic        done,
	output rsp_t        result,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [14:0] cfg_wdata
);

	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int HTW  = 8 + $clog2(TRACKS_PER_CYL);

	logic            v_s1;
	req_t            req_s1;
	logic [HTW-1:0]  hthr_s1;

	logic [CNTW-1:0] count_q;
	logic [CNTW-1:0] count_nx;
	logic [10:0]     max_block_q;
	logic [14:0]     max_size_q;

	cell_ctl_t       ctl;
	logic [1:0]      kind;
	logic            accept;

	ent_t                   ent_vec  [QUEUE_DEPTH];
	ent_t                   pick_vec [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] le_vec;
	logic [QUEUE_DEPTH-1:0] qual_vec;
	logic [QUEUE_DEPTH-1:0] sel_vec;
	logic [QUEUE_DEPTH-1:0] occ_vec;
	ent_t                   pick;

	logic       v_s2;
	logic [1:0] kind_s2;
	ent_t       pick_s2;
	logic [5:0] level_s2;

	assign busy   = v_s1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// The head threshold is formed here so that the cells only compare.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= cmd;
			hthr_s1 <= HTW'(cmd.head_cyl) * HTW'(TRACKS_PER_CYL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_block_q <= MAX_BLOCK_RST;
			max_size_q  <= MAX_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_BLOCK: max_block_q <= cfg_wdata[10:0];
				REG_MAX_SIZE:  max_size_q  <= cfg_wdata;
			endcase
		end
	end

	always_comb begin
		ctl.new_ent.key  = req_s1.req_block;
		ctl.new_ent.op   = req_s1.req_op;
		ctl.new_ent.id   = req_s1.req_id;
		ctl.new_ent.size = req_s1.req_size;
		ctl.new_ent.addr = req_s1.req_addr;
		ctl.any_qual     = |qual_vec;
		ctl.cmd          = CMD_HOLD;
		kind             = KIND_ACCEPTED;
		count_nx         = count_q;
		priority if (!v_s1) begin
			ctl.cmd = CMD_HOLD;
		end else if (req_s1.mode == MODE_ENQ) begin
			if (count_q == CNTW'(QUEUE_DEPTH)) begin
				kind = KIND_DROPPED;
			end else begin
				ctl.cmd  = CMD_ENQ;
				kind     = KIND_ACCEPTED;
				count_nx = count_q + CNTW'(1);
			end
		end else if (count_q == '0) begin
			kind = KIND_EMPTY;
		end else begin
			ctl.cmd  = CMD_DEQ;
			kind     = KIND_DISPATCHED;
			count_nx = count_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nx;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign occ_vec[i] = count_q > CNTW'(i);

		if (i == 0) begin : g_head
			dreq_cell #(
				.TRACKS_PER_CYL(TRACKS_PER_CYL),
				.FIRST(1'b1)
			) u_cell (
				.clk(clk),
				.ctl(ctl),
				.hthr(hthr_s1),
				.occ(occ_vec[i]),
				.left_ent(ctl.new_ent),
				.left_le(1'b1),
				.left_qual(1'b0),
				.right_ent(ent_vec[(i + 1) % QUEUE_DEPTH]),
				.ent(ent_vec[i]),
				.le(le_vec[i]),
				.qual(qual_vec[i]),
				.sel(sel_vec[i]),
				.pick(pick_vec[i])
			);
		end else if (i == QUEUE_DEPTH - 1) begin : g_tail
			dreq_cell #(
				.TRACKS_PER_CYL(TRACKS_PER_CYL),
				.FIRST(1'b0)
			) u_cell (
				.clk(clk),
				.ctl(ctl),
				.hthr(hthr_s1),
				.occ(occ_vec[i]),
				.left_ent(ent_vec[i - 1]),
				.left_le(le_vec[i - 1]),
				.left_qual(qual_vec[i - 1]),
				.right_ent(ent_vec[i]),
				.ent(ent_vec[i]),
				.le(le_vec[i]),
				.qual(qual_vec[i]),
				.sel(sel_vec[i]),
				.pick(pick_vec[i])
			);
		end else begin : g_mid
			dreq_cell #(
				.TRACKS_PER_CYL(TRACKS_PER_CYL),
				.FIRST(1'b0)
			) u_cell (
				.clk(clk),
				.ctl(ctl),
				.hthr(hthr_s1),
				.occ(occ_vec[i]),
				.left_ent(ent_vec[i - 1]),
				.left_le(le_vec[i - 1]),
				.left_qual(qual_vec[i - 1]),
				.right_ent(ent_vec[i + 1]),
				.ent(ent_vec[i]),
				.le(le_vec[i]),
				.qual(qual_vec[i]),
				.sel(sel_vec[i]),
				.pick(pick_vec[i])
			);
		end
	end

	// Exactly one cell offers its entry on a dispatch, so an OR collects it.
	always_comb begin
		pick = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			pick = pick | pick_vec[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			kind_s2  <= kind;
			pick_s2  <= pick;
			level_s2 <= 6'(count_nx);
		end
	end

	dreq_post #(
		.TRACKS_PER_CYL(TRACKS_PER_CYL)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.v_s2(v_s2),
		.kind_s2(kind_s2),
		.pick_s2(pick_s2),
		.level_s2(level_s2),
		.max_block(max_block_q),
		.max_size(max_size_q),
		.done(done),
		.result(result)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(QUEUE_DEPTH))
		else $error("fill count beyond table depth");

	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (ctl.cmd == CMD_DEQ) |-> $onehot(sel_vec))
		else $error("dispatch must select exactly one slot");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (ctl.cmd == CMD_ENQ) |=> count_q == $past(count_q) + CNTW'(1))
		else $error("insert did not raise the fill count");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("result strobe missing four edges after a request");

endmodule

[dv/disk_request_elevator_queue_tb.sv]
// ----------------------------------------------------------------------------
// disk_request_elevator_queue_tb
// Self-checking bench for the sorted disk request table with C-LOOK dispatch.
// Every request is also applied to a behavioural copy of the table. Its result
// is queued and compared field by field with each result strobe. Directed
// requests cover the field extremes and the flag cases. Random traffic then
// fills and drains the table under several register settings, with random
// gaps between requests and in one run back to back.
// ----------------------------------------------------------------------------
module disk_request_elevator_queue_tb;
	import dreq_pkg::*;

	localparam int QDEPTH       = 32;
	localparam int TRACKS       = 9;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic [3:0] FLAG_OP    = 4'b0001;
	localparam logic [3:0] FLAG_ID    = 4'b0010;
	localparam logic [3:0] FLAG_BLOCK = 4'b0100;
	localparam logic [3:0] FLAG_SIZE  = 4'b1000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        cmd;
	logic        done;
	rsp_t        result;
	logic        cfg_we;
	logic        cfg_idx;
	logic [14:0] cfg_wdata;

	// Behavioural copy of the table and registers
	ent_t        pending_reqs[$];
	rsp_t        due_results[$];
	logic [10:0] cfg_max_block;
	logic [14:0] cfg_max_size;

	int gap_max;
	int errors;
	int cycle_count;
	int n_queued, n_dropped, n_dispatched, n_flagged, n_empty, n_settings, peak_level;

	disk_request_elevator_queue #(
		.QUEUE_DEPTH   (QDEPTH),
		.TRACKS_PER_CYL(TRACKS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time,
				due_results.size());
			$display("disk_request_elevator_queue test failed");
			$finish;
		end
	end

	function automatic int cylinder_of(input logic signed [11:0] blk);
		// Division truncates toward zero, so blocks -7 to 9 all map to cylinder 0.
		return (int'(blk) - 1) / TRACKS;
	endfunction

	function automatic void apply_to_model(input req_t rq);
		rsp_t r;
		ent_t e;
		int pos, blk, sz, b1, cyl, rem, sec;
		logic [3:0] flags;
		r = '0;
		if (rq.mode == MODE_ENQ) begin
			if (pending_reqs.size() >= QDEPTH) begin
				r.kind = KIND_DROPPED;
				n_dropped++;
			end else begin
				e.key  = rq.req_block;
				e.op   = rq.req_op;
				e.id   = rq.req_id;
				e.size = rq.req_size;
				e.addr = rq.req_addr;
				// Equal keys keep their arrival order.
				pos = 0;
				while (pos < pending_reqs.size() &&
						$signed(pending_reqs[pos].key) <= $signed(rq.req_block))
					pos++;
				pending_reqs.insert(pos, e);
				r.kind = KIND_ACCEPTED;
				n_queued++;
			end
		end else if (pending_reqs.size() == 0) begin
			r.kind = KIND_EMPTY;
			n_empty++;
		end else begin
			pos = 0;
			while (pos < pending_reqs.size() &&
					cylinder_of(pending_reqs[pos].key) < int'(rq.head_cyl))
				pos++;
			if (pos >= pending_reqs.size())
				pos = 0;
			e = pending_reqs[pos];
			pending_reqs.delete(pos);
			blk = $signed(e.key);
			sz = $signed(e.size);
			flags = '0;
			if (e.op != OP_READ && e.op != OP_WRITE)
				flags |= FLAG_OP;
			if ($signed(e.id) <= 0)
				flags |= FLAG_ID;
			if (blk < 1 || blk > int'(cfg_max_block))
				flags |= FLAG_BLOCK;
			if (sz < 0 || (sz & (sz - 1)) != 0 || sz > int'(cfg_max_size))
				flags |= FLAG_SIZE;
			r.kind        = KIND_DISPATCHED;
			r.out_op      = e.op;
			r.out_id      = e.id;
			r.out_block   = e.key;
			r.out_size    = e.size;
			r.out_addr    = e.addr;
			r.error_flags = flags;
			if (flags == '0) begin
				b1 = blk - 1;
				cyl = b1 / TRACKS;
				rem = b1 % TRACKS;
				if (rem <= TRACKS / 2) begin
					r.out_track = 1'b0;
					sec = rem * 2;
				end else begin
					r.out_track = 1'b1;
					sec = rem * 2 - TRACKS;
				end
				r.out_cyl  = (cyl > 255) ? 8'd255 : 8'(cyl);
				r.out_sect = (sec > 15) ? 4'd15 : 4'(sec);
			end else begin
				n_flagged++;
			end
			n_dispatched++;
		end
		r.queue_level = 6'(pending_reqs.size());
		if (pending_reqs.size() > peak_level)
			peak_level = pending_reqs.size();
		due_results.push_back(r);
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n) begin
			if ($isunknown(done)) begin
				$display("%0t: done expected 0 or 1 got %b", $time, done);
				errors++;
			end else if (done) begin
				if (due_results.size() == 0) begin
					$display("%0t: result %h expected none", $time, result);
					errors++;
				end else begin
					exp_r = due_results.pop_front();
					check_field("kind", exp_r.kind, result.kind);
					check_field("out_op", exp_r.out_op, result.out_op);
					check_field("out_id", exp_r.out_id, result.out_id);
					check_field("out_block", exp_r.out_block, result.out_block);
					check_field("out_size", exp_r.out_size, result.out_size);
					check_field("out_addr", exp_r.out_addr, result.out_addr);
					check_field("error_flags", exp_r.error_flags, result.error_flags);
					check_field("out_cyl", exp_r.out_cyl, result.out_cyl);
					check_field("out_track", exp_r.out_track, result.out_track);
					check_field("out_sect", exp_r.out_sect, result.out_sect);
					check_field("queue_level", exp_r.queue_level, result.queue_level);
				end
			end
		end
	end

	function automatic req_t junk_request();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	// Holds start low for a random gap, then presents the request until taken.
	task automatic send_request(input req_t rq);
		int gap;
		gap = (gap_max == 0 || $urandom_range(3, 0) == 0) ? 0 : $urandom_range(gap_max, 1);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			cmd <= junk_request();
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= rq;
		do @(posedge clk); while (busy);
		apply_to_model(rq);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [14:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 15'($urandom);
		if (idx == REG_MAX_BLOCK)
			cfg_max_block = value[10:0];
		else
			cfg_max_size = value[14:0];
	endtask

	task automatic set_limits(input logic [10:0] blk, input logic [14:0] size);
		wait_for_results();
		// The upper bits of the block limit write are ignored by the block.
		write_register(REG_MAX_BLOCK, {4'($urandom), blk});
		write_register(REG_MAX_SIZE, size);
		n_settings++;
	endtask

	function automatic req_t make_enqueue(input logic [3:0] op, input int id, input int blk,
			input int size, input logic [31:0] addr);
		req_t rq;
		rq = junk_request();
		rq.mode      = MODE_ENQ;
		rq.req_op    = op;
		rq.req_id    = 16'(id);
		rq.req_block = 12'(blk);
		rq.req_size  = 16'(size);
		rq.req_addr  = addr;
		return rq;
	endfunction

	function automatic req_t make_dispatch(input int head);
		req_t rq;
		rq = junk_request();
		rq.mode     = MODE_DEQ;
		rq.head_cyl = 8'(head);
		return rq;
	endfunction

	function automatic req_t random_request(input int enq_pct);
		req_t rq;
		int pick;
		rq.mode = ($urandom_range(99, 0) < enq_pct) ? MODE_ENQ : MODE_DEQ;
		if ($urandom_range(9, 0) < 7)
			rq.req_op = $urandom_range(1, 0) ? OP_READ : OP_WRITE;
		else
			rq.req_op = 4'($urandom);
		rq.req_id = ($urandom_range(4, 0) != 0) ? 16'($urandom_range(32767, 1))
			: 16'($urandom);
		pick = $urandom_range(19, 0);
		if (pick < 14)
			rq.req_block = 12'($urandom_range(int'(cfg_max_block), 1));
		else if (pick < 17) begin
			case ($urandom_range(3, 0))
				0: rq.req_block = 12'd0;
				1: rq.req_block = 12'd1;
				2: rq.req_block = 12'(cfg_max_block);
				default: rq.req_block = 12'(int'(cfg_max_block) + 1);
			endcase
		end else
			rq.req_block = 12'($urandom);
		pick = $urandom_range(19, 0);
		if (pick < 12)
			rq.req_size = 16'(1 << $urandom_range(15, 0));
		else if (pick < 15)
			rq.req_size = 16'd0;
		else if (pick < 17)
			rq.req_size = 16'(cfg_max_size);
		else
			rq.req_size = 16'($urandom);
		rq.req_addr = $urandom;
		rq.head_cyl = $urandom_range(1, 0) ? 8'($urandom)
			: 8'($urandom_range(int'(cfg_max_block) / TRACKS + 1, 0));
		return rq;
	endfunction

	// Alternates filling and draining runs so the table reaches full and empty.
	task automatic run_mixed(input int count);
		int left, run;
		bit filling;
		left = count;
		filling = 1'b0;
		while (left > 0) begin
			filling = !filling;
			run = $urandom_range(60, 10);
			while (run > 0 && left > 0) begin
				send_request(random_request(filling ? 85 : 20));
				run--;
				left--;
			end
		end
	endtask

	task automatic test_directed_cases();
		gap_max = 3;
		send_request(make_dispatch(0));
		send_request(make_enqueue(OP_READ, 1, 1, 0, 32'h0000_0000));
		send_request(make_enqueue(OP_WRITE, 32767, 360, 8192, 32'hFFFF_FFFF));
		send_request(make_enqueue(4'd0, 0, 0, -1, 32'h5A5A_5A5A));
		send_request(make_enqueue(4'd15, -32768, -2048, -32768, 32'hA5A5_A5A5));
		send_request(make_enqueue(4'd3, -1, 2047, 16384, 32'h1234_5678));
		send_request(make_enqueue(OP_READ, 5, 361, 3, 32'h8765_4321));
		send_request(make_enqueue(OP_WRITE, 7, 100, 512, 32'h0000_0100));
		send_request(make_enqueue(OP_READ, 8, 100, 1024, 32'h0000_0200));
		send_request(make_enqueue(OP_READ, 9, 9, 1, 32'h0000_0300));
		send_request(make_enqueue(OP_WRITE, 10, 5, 2, 32'h0000_0400));
		send_request(make_enqueue(OP_READ, 11, 6, 4, 32'h0000_0500));
		// No entry reaches cylinder 255, so the lowest block is taken.
		send_request(make_dispatch(255));
		send_request(make_dispatch(11));
		send_request(make_dispatch(11));
		send_request(make_dispatch(0));
		send_request(make_dispatch(40));
		send_request(make_dispatch(227));
		repeat (6) send_request(make_dispatch(0));
	endtask

	task automatic test_fill_and_drain();
		gap_max = 3;
		run_mixed(300);
	endtask

	task automatic test_back_to_back();
		gap_max = 0;
		run_mixed(250);
	endtask

	task automatic test_tight_limits();
		set_limits(11'd1, 15'd1);
		gap_max = 3;
		run_mixed(200);
	endtask

	task automatic test_wide_limits();
		set_limits(11'd2047, 15'd32767);
		gap_max = 2;
		run_mixed(200);
	endtask

	task automatic test_random_limits();
		repeat (3) begin
			set_limits(11'($urandom_range(2047, 1)), 15'($urandom_range(32767, 1)));
			gap_max = $urandom_range(3, 0);
			run_mixed(200);
		end
		set_limits(MAX_BLOCK_RST, MAX_SIZE_RST);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_MAX_BLOCK;
		cfg_wdata = '0;
		cfg_max_block = MAX_BLOCK_RST;
		cfg_max_size = MAX_SIZE_RST;
		gap_max = 3;
		errors = 0;
		cycle_count = 0;
		n_queued = 0;
		n_dropped = 0;
		n_dispatched = 0;
		n_flagged = 0;
		n_empty = 0;
		n_settings = 0;
		peak_level = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_fill_and_drain();
		test_back_to_back();
		test_tight_limits();
		test_wide_limits();
		test_random_limits();
		wait_for_results();

		$display("Requests: %0d queued, %0d dropped on a full table, %0d dispatched",
			n_queued, n_dropped, n_dispatched);
		$display("(%0d with flags), %0d on an empty table; %0d limit settings, peak %0d.",
			n_flagged, n_empty, n_settings, peak_level);
		if (errors == 0)
			$display("disk_request_elevator_queue test passed");
		else
			$display("disk_request_elevator_queue test failed");
		$finish;
	end

endmodule

[sim.f]
sv/dreq_pkg.sv
sv/dreq_cell.sv
sv/dreq_post.sv
sv/disk_request_elevator_queue.sv
dv/disk_request_elevator_queue_tb.sv
